### design/color_usage_histogram_macros.svh
// assertion macros for the color usage histogram modules
// expects clk and rst_n in the scope of each use
`ifndef COLOR_USAGE_HISTOGRAM_MACROS_SVH
`define COLOR_USAGE_HISTOGRAM_MACROS_SVH

// condition holds at every clock edge out of reset
`define CUH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define CUH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/cuh_pkg.sv
// types and constants of the color usage histogram
// no dependencies
package cuh_pkg;

  localparam int NUM_COLORS  = 256;
  localparam int COUNT_BITS  = 24;
  localparam int BIN_IDX_W   = $clog2(NUM_COLORS);
  localparam int COLOR_W     = 8;
  localparam int BIN_FIELD_W = 24;
  localparam int DISTINCT_W  = 9;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [BIN_FIELD_W-1:0] BIN_FIELD_MAX = {BIN_FIELD_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  localparam logic KIND_DISTINCT = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COLOR_W-1:0] color;
    logic               last_pixel;
  } in_req_t;

  typedef struct packed {
    logic                   kind;
    logic [BIN_FIELD_W-1:0] bin_count;
    logic [DISTINCT_W-1:0]  distinct_colors;
  } out_res_t;

  // count memory write port
  typedef struct packed {
    logic                  we;
    logic [BIN_IDX_W-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } cnt_wr_t;

endpackage

### design/color_usage_histogram.sv
// color usage histogram top level: request register, count memory, update logic
// depends on cuh_pkg, cuh_count_ram and cuh_bin_ctrl
//
// Usage:
//   A request (in_req: cmd, color, last_pixel) is taken at a rising edge with
//   start high and busy low. busy stays low, so one request can be taken every
//   cycle, including back-to-back pixels of the same color.
//   Commands: clear empties all 256 bins and the distinct count;
//   pixel adds one to its bin, saturating; read returns one bin's count.
//   A pixel with last_pixel set gives a distinct-color report; a read gives a
//   bin answer. Clears and plain pixels give no result.
//   Timing: the result shows on out_res with out_valid high for exactly one
//   cycle, after the request register and then the output register.
//   Throughput: one request per cycle, set by the single read and write port
//   of the count memory; a same-bin update in the next cycle is forwarded
//   around the memory.
//   The receiver cannot stall, so results are never held.
//   Reset (rst_n low, synchronous) empties all bins and the distinct count;
//   the count memory itself needs no clearing.
module color_usage_histogram
  import cuh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  logic                  accept;
  logic                  s1_valid_r;
  in_req_t               s1_req_r;
  logic [COUNT_BITS-1:0] ram_q;
  cnt_wr_t               wr;
  logic                  res_valid;
  out_res_t              res;
  logic                  out_valid_r;
  out_res_t              out_res_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_req;
    end
    out_res_r <= res;
  end

  cuh_count_ram u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_req.color[BIN_IDX_W-1:0]),
    .rd_data (ram_q),
    .wr      (wr)
  );

  cuh_bin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_valid_r),
    .req       (s1_req_r),
    .ram_q     (ram_q),
    .wr        (wr),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### design/cuh_count_ram.sv
// bin count memory: one write port, one registered read port
// depends on cuh_pkg
module cuh_count_ram
  import cuh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [BIN_IDX_W-1:0]  rd_addr,
  output logic [COUNT_BITS-1:0] rd_data,
  input  cnt_wr_t               wr
);

  logic [COUNT_BITS-1:0] mem_r [NUM_COLORS];
  logic [COUNT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/cuh_bin_ctrl.sv
// used bits, distinct count, count update with forwarding and result forming
// depends on cuh_pkg and color_usage_histogram_macros.svh
`include "color_usage_histogram_macros.svh"

module cuh_bin_ctrl
  import cuh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  in_req_t               req,
  input  logic [COUNT_BITS-1:0] ram_q,
  output cnt_wr_t               wr,
  output logic                  res_valid,
  output out_res_t              res
);

  logic [NUM_COLORS-1:0] used_r, used_nxt;
  logic [DISTINCT_W-1:0] distinct_r, distinct_nxt;
  cnt_wr_t               fwd_r;

  logic [BIN_IDX_W-1:0]  idx;
  logic                  in_range;
  logic                  hit_used;
  logic [COUNT_BITS-1:0] stored;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic                  is_clear, is_pixel, is_read, do_count;

  function automatic logic [BIN_FIELD_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'(BIN_FIELD_MAX)) begin
      return BIN_FIELD_MAX;
    end
    return w[BIN_FIELD_W-1:0];
  endfunction

  assign idx      = req.color[BIN_IDX_W-1:0];
  assign in_range = {1'b0, req.color} < (COLOR_W+1)'(NUM_COLORS);
  assign hit_used = in_range && used_r[idx];

  // previous request wrote at the edge that read this one
  assign stored = (fwd_r.we && fwd_r.addr == idx) ? fwd_r.data : ram_q;
  assign cur    = hit_used ? stored : '0;
  assign inc    = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  assign is_clear = req_valid && req.cmd == CMD_CLEAR;
  assign is_pixel = req_valid && req.cmd == CMD_PIXEL;
  assign is_read  = req_valid && req.cmd == CMD_READ;
  assign do_count = is_pixel && in_range;

  always_comb begin
    wr.we   = do_count;
    wr.addr = idx;
    wr.data = inc;
  end

  always_comb begin
    used_nxt     = used_r;
    distinct_nxt = distinct_r;
    if (is_clear) begin
      used_nxt     = '0;
      distinct_nxt = '0;
    end else if (do_count) begin
      used_nxt[idx] = 1'b1;
      if (!hit_used) begin
        distinct_nxt = distinct_r + 1'b1;
      end
    end
  end

  always_comb begin
    res_valid           = 1'b0;
    res.kind            = KIND_DISTINCT;
    res.bin_count       = '0;
    res.distinct_colors = distinct_nxt;
    if (is_pixel && req.last_pixel) begin
      res_valid = 1'b1;
    end else if (is_read) begin
      res_valid           = 1'b1;
      res.kind            = KIND_READ;
      res.bin_count       = clamp_count(cur);
      res.distinct_colors = distinct_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      distinct_r <= '0;
      fwd_r.we   <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      distinct_r <= distinct_nxt;
      fwd_r.we   <= wr.we;
    end
    fwd_r.addr <= wr.addr;
    fwd_r.data <= wr.data;
  end

  `CUH_ASSERT_ALWAYS(a_distinct_matches_used, $countones(used_r) == 32'(distinct_r), "distinct count disagrees with used bits")
  `CUH_ASSERT_NEXT(a_clear_empties, is_clear, used_r == '0 && distinct_r == '0, "clear left state behind")
  `CUH_ASSERT_ALWAYS(a_count_no_wrap, !wr.we || wr.data != '0, "bin count wrapped to zero")

endmodule
